// File: hdl/typed_zone_point_in_polygon_defines.svh
// Assertion helpers used by the top RTL file of the typed zone point-in-polygon block.
// Both helpers expect the enclosing module to have ports named clock and reset.
`ifndef TYPED_ZONE_POINT_IN_POLYGON_DEFINES_SVH
`define TYPED_ZONE_POINT_IN_POLYGON_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TZPIP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TZPIP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/tzpip_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tzpip_pkg;

   localparam int MAX_ZONES    = 16;
   localparam int MAX_VERTICES = 32;
   localparam int MIN_VERTICES = 3;

   localparam int ZONE_W      = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
   localparam int VIDX_W      = $clog2(MAX_VERTICES);
   localparam int CNT_W       = $clog2(MAX_VERTICES + 1);
   localparam int STORE_DEPTH = MAX_ZONES * MAX_VERTICES;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam int COORD_W = 32;
   localparam int TYPE_W  = 4;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int SUM_W   = PROD_W + 1;

   typedef enum logic [1:0] {
      MODE_VERTEX = 2'd0,
      MODE_HEADER = 2'd1,
      MODE_QUERY  = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ZONE,
      S_PREV,
      S_EDGE,
      S_MUL_A,
      S_MUL_B,
      S_CMP,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

// File: hdl/tzpip_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tzpip_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

// File: hdl/typed_zone_point_in_polygon.sv
`timescale 1ns / 1ps
`default_nettype none
`include "typed_zone_point_in_polygon_defines.svh"

// Typed polygon zone lookup. Vertex writes, header writes, queries with no pose and the
// unused mode give their response in the cycle after they are accepted. A query with
// a pose walks the zones in index order. A zone that is not valid, or is of another type,
// is skipped in S_ZONE. A zone that is tested fetches its closing vertex through S_ZONE
// and S_PREV, then walks its edges in S_EDGE, adding S_MUL_A, S_MUL_B and S_CMP for an
// edge whose end points lie on both sides of the point's y. S_DONE then hands the answer
// to the response register once it is free. The vertex RAM gives one vertex a cycle, and
// the single 33 x 33 multiplier forms the two cross products of an edge one after the
// other. No new transaction is taken while a query runs.
module typed_zone_point_in_polygon (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_mode,
   input  wire logic [3:0]  req_zone_index,
   input  wire logic [4:0]  req_vertex_index,
   input  wire logic [31:0] req_coord_x,
   input  wire logic [31:0] req_coord_y,
   input  wire logic [3:0]  req_type_code,
   input  wire logic [5:0]  req_vertex_count,
   input  wire logic        req_pose_valid,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_is_query,
   output logic             rsp_inside_res,
   output logic [3:0]       rsp_matched_zone
);

   import tzpip_pkg::*;

   function automatic logic [ADDR_W-1:0] vtx_addr(input logic [ZONE_W-1:0] z,
                                                  input logic [VIDX_W-1:0] i);
      vtx_addr = ADDR_W'(int'(z) * MAX_VERTICES + int'(i));
   endfunction

   state_type state_ff, state_in;

   logic [ZONE_W-1:0] zone_ff, zone_in;
   logic [VIDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic              parity_ff, parity_in;
   logic              found_ff, found_in;

   logic signed [COORD_W-1:0] px_ff, px_in, py_ff, py_in;
   logic [TYPE_W-1:0]         want_ff, want_in;
   logic signed [COORD_W-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [COORD_W-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [DIFF_W-1:0]  dxp_ff, dxp_in, dy_ff, dy_in;
   logic signed [DIFF_W-1:0]  dxe_ff, dxe_in, dyp_ff, dyp_in;
   logic signed [PROD_W-1:0]  prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_is_query_ff, rsp_is_query_in;
   logic       rsp_inside_res_ff, rsp_inside_res_in;
   logic [3:0] rsp_matched_zone_ff, rsp_matched_zone_in;

   logic [TYPE_W-1:0] zone_type_ff [MAX_ZONES];
   logic [CNT_W-1:0]  zone_cnt_ff [MAX_ZONES];

   logic              req_acc;
   logic              vtx_we, hdr_we;
   logic [ADDR_W-1:0] wr_addr;
   logic [CNT_W-1:0]  sat_cnt;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [COORD_W-1:0] rdata_x, rdata_y;
   logic signed [COORD_W-1:0] rx, ry;

   logic signed [DIFF_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic signed [SUM_W-1:0]  cmp_diff;
   logic                     toggle;
   logic                     crossing;
   logic                     zone_ok;
   logic                     zone_last;
   logic                     edge_last;
   logic                     do_step;
   logic signed [COORD_W-1:0] step_x, step_y;
   logic                     step_par;

   assign req_acc   = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_query     = rsp_is_query_ff;
   assign rsp_inside_res   = rsp_inside_res_ff;
   assign rsp_matched_zone = rsp_matched_zone_ff;

   // Table writes only happen while idle, so they never collide with a query's reads.
   assign vtx_we = req_acc && (req_mode == MODE_VERTEX) &&
                   (int'(req_zone_index) < MAX_ZONES) && (int'(req_vertex_index) < MAX_VERTICES);
   assign hdr_we = req_acc && (req_mode == MODE_HEADER) && (int'(req_zone_index) < MAX_ZONES);
   assign wr_addr = vtx_addr(ZONE_W'(req_zone_index), VIDX_W'(req_vertex_index));
   assign sat_cnt = (int'(req_vertex_count) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES)
                                                            : CNT_W'(req_vertex_count);

   tzpip_ram #(
      .WIDTH (COORD_W),
      .DEPTH (STORE_DEPTH)
   ) u_vertex_x_store (
      .clock (clock),
      .we    (vtx_we),
      .waddr (wr_addr),
      .wdata (req_coord_x),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (rdata_x)
   );

   tzpip_ram #(
      .WIDTH (COORD_W),
      .DEPTH (STORE_DEPTH)
   ) u_vertex_y_store (
      .clock (clock),
      .we    (vtx_we),
      .waddr (wr_addr),
      .wdata (req_coord_y),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (rdata_y)
   );

   assign rx = $signed(rdata_x);
   assign ry = $signed(rdata_y);

   // The one multiplier serves both cross products of an edge.
   assign mul_a = (state_ff == S_MUL_A) ? dxp_ff : dxe_ff;
   assign mul_b = (state_ff == S_MUL_A) ? dy_ff : dyp_ff;
   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   // The ray crosses right of the point when (px - xi) * dy falls below (xj - xi) * (py - yi)
   // for a rising edge, or above it for a falling one.
   assign cmp_diff = SUM_W'(prod_a_ff) - SUM_W'(prod_b_ff);
   assign toggle   = dy_ff[DIFF_W-1] ? (!cmp_diff[SUM_W-1] && (cmp_diff != '0))
                                     : cmp_diff[SUM_W-1];

   assign crossing  = (ry > py_ff) != (prev_y_ff > py_ff);
   assign zone_ok   = (zone_cnt_ff[zone_ff] >= CNT_W'(MIN_VERTICES)) &&
                      (zone_type_ff[zone_ff] == want_ff);
   assign zone_last = (zone_ff == ZONE_W'(MAX_ZONES - 1));
   assign edge_last = ((CNT_W'(idx_ff) + CNT_W'(1)) == n_ff);

   assign step_x   = (state_ff == S_EDGE) ? rx : cur_x_ff;
   assign step_y   = (state_ff == S_EDGE) ? ry : cur_y_ff;
   assign step_par = (state_ff == S_CMP) ? (parity_ff ^ toggle) : parity_ff;

   always_comb begin
      state_in  = state_ff;
      zone_in   = zone_ff;
      idx_in    = idx_ff;
      n_in      = n_ff;
      parity_in = parity_ff;
      found_in  = found_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      want_in   = want_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      dxp_in    = dxp_ff;
      dy_in     = dy_ff;
      dxe_in    = dxe_ff;
      dyp_in    = dyp_ff;
      prod_a_in = prod_a_ff;
      prod_b_in = prod_b_ff;
      rd_en     = 1'b0;
      rd_addr   = '0;
      do_step   = 1'b0;

      rsp_valid_in        = rsp_valid_ff && rsp_stall;
      rsp_is_query_in     = rsp_is_query_ff;
      rsp_inside_res_in   = rsp_inside_res_ff;
      rsp_matched_zone_in = rsp_matched_zone_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if ((req_mode == MODE_QUERY) && req_pose_valid) begin
                  px_in    = $signed(req_coord_x);
                  py_in    = $signed(req_coord_y);
                  want_in  = req_type_code;
                  zone_in  = '0;
                  state_in = S_ZONE;
               end else begin
                  // Writes, the unused mode and queries without a pose answer at once.
                  rsp_valid_in        = 1'b1;
                  rsp_is_query_in     = (req_mode == MODE_QUERY);
                  rsp_inside_res_in   = 1'b0;
                  rsp_matched_zone_in = '0;
               end
            end
         end
         S_ZONE: begin
            if (zone_ok) begin
               n_in      = zone_cnt_ff[zone_ff];
               parity_in = 1'b0;
               rd_en     = 1'b1;
               rd_addr   = vtx_addr(zone_ff, VIDX_W'(zone_cnt_ff[zone_ff] - CNT_W'(1)));
               state_in  = S_PREV;
            end else if (zone_last) begin
               found_in = 1'b0;
               state_in = S_DONE;
            end else begin
               zone_in = zone_ff + ZONE_W'(1);
            end
         end
         S_PREV: begin
            // The closing vertex starts the walk as the first edge's far end.
            prev_x_in = rx;
            prev_y_in = ry;
            idx_in    = '0;
            rd_en     = 1'b1;
            rd_addr   = vtx_addr(zone_ff, '0);
            state_in  = S_EDGE;
         end
         S_EDGE: begin
            cur_x_in = rx;
            cur_y_in = ry;
            dxp_in   = DIFF_W'(px_ff) - DIFF_W'(rx);
            dy_in    = DIFF_W'(prev_y_ff) - DIFF_W'(ry);
            dxe_in   = DIFF_W'(prev_x_ff) - DIFF_W'(rx);
            dyp_in   = DIFF_W'(py_ff) - DIFF_W'(ry);
            if (crossing) begin
               state_in = S_MUL_A;
            end else begin
               do_step = 1'b1;
            end
         end
         S_MUL_A: begin
            prod_a_in = mul_p;
            state_in  = S_MUL_B;
         end
         S_MUL_B: begin
            prod_b_in = mul_p;
            state_in  = S_CMP;
         end
         S_CMP: begin
            do_step = 1'b1;
         end
         S_DONE: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in        = 1'b1;
               rsp_is_query_in     = 1'b1;
               rsp_inside_res_in   = found_ff;
               rsp_matched_zone_in = found_ff ? 4'(zone_ff) : 4'd0;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (do_step) begin
         prev_x_in = step_x;
         prev_y_in = step_y;
         parity_in = step_par;
         if (edge_last) begin
            if (step_par) begin
               found_in = 1'b1;
               state_in = S_DONE;
            end else if (zone_last) begin
               found_in = 1'b0;
               state_in = S_DONE;
            end else begin
               zone_in  = zone_ff + ZONE_W'(1);
               state_in = S_ZONE;
            end
         end else begin
            idx_in   = idx_ff + VIDX_W'(1);
            rd_en    = 1'b1;
            rd_addr  = vtx_addr(zone_ff, idx_ff + VIDX_W'(1));
            state_in = S_EDGE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int z = 0; z < MAX_ZONES; z++) begin
            zone_type_ff[z] <= '0;
            zone_cnt_ff[z]  <= '0;
         end
      end else if (hdr_we) begin
         zone_type_ff[ZONE_W'(req_zone_index)] <= req_type_code;
         zone_cnt_ff[ZONE_W'(req_zone_index)]  <= sat_cnt;
      end
   end

   always_ff @(posedge clock) begin
      zone_ff             <= zone_in;
      idx_ff              <= idx_in;
      n_ff                <= n_in;
      parity_ff           <= parity_in;
      found_ff            <= found_in;
      px_ff               <= px_in;
      py_ff               <= py_in;
      want_ff             <= want_in;
      prev_x_ff           <= prev_x_in;
      prev_y_ff           <= prev_y_in;
      cur_x_ff            <= cur_x_in;
      cur_y_ff            <= cur_y_in;
      dxp_ff              <= dxp_in;
      dy_ff               <= dy_in;
      dxe_ff              <= dxe_in;
      dyp_ff              <= dyp_in;
      prod_a_ff           <= prod_a_in;
      prod_b_ff           <= prod_b_in;
      rsp_is_query_ff     <= rsp_is_query_in;
      rsp_inside_res_ff   <= rsp_inside_res_in;
      rsp_matched_zone_ff <= rsp_matched_zone_in;
   end

   `TZPIP_ASSERT_NOW(a_inside_is_query, rsp_valid_ff && rsp_inside_res_ff, rsp_is_query_ff, "inside reported for a transaction that is not a query")
   `TZPIP_ASSERT_NOW(a_outside_zone_zero, rsp_valid_ff && !rsp_inside_res_ff, rsp_matched_zone_ff == 4'd0, "zone reported without a match")
   `TZPIP_ASSERT_NOW(a_edge_in_zone, state_ff == S_EDGE, CNT_W'(idx_ff) < n_ff, "edge walk ran past the zone's vertex count")
   `TZPIP_ASSERT_NEXT(a_query_starts_walk, req_acc && (req_mode == MODE_QUERY) && req_pose_valid, state_ff == S_ZONE, "query with a pose did not start the zone walk")

endmodule

`default_nettype wire

// File: tb/zone_query_checker.sv
`timescale 1ns / 1ps

module zone_query_checker
   import tzpip_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [1:0]  req_mode,
   input  wire logic [3:0]  req_zone_index,
   input  wire logic [4:0]  req_vertex_index,
   input  wire logic [31:0] req_coord_x,
   input  wire logic [31:0] req_coord_y,
   input  wire logic [3:0]  req_type_code,
   input  wire logic [5:0]  req_vertex_count,
   input  wire logic        req_pose_valid,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic        rsp_is_query,
   input  wire logic        rsp_inside_res,
   input  wire logic [3:0]  rsp_matched_zone,
   output int               fail_count,
   output int               outstanding,
   output int               inside_count
);

   typedef struct packed {
      logic       is_query;
      logic       hit;
      logic [3:0] zone;
   } zone_answer_type;

   logic signed [COORD_W-1:0] vert_x [MAX_ZONES][MAX_VERTICES];
   logic signed [COORD_W-1:0] vert_y [MAX_ZONES][MAX_VERTICES];
   logic [TYPE_W-1:0]         zone_kind [MAX_ZONES];
   logic [CNT_W-1:0]          zone_count [MAX_ZONES];
   zone_answer_type           answer_queue [$];

   // Crossing-number test toward +x. The crossing abscissa is compared without a
   // division: both sides are multiplied by dy, which flips the sense when dy < 0.
   function automatic logic point_in_zone(input int z, input logic signed [COORD_W-1:0] px,
                                          input logic signed [COORD_W-1:0] py);
      logic                      odd;
      int                        n, i, j;
      logic signed [COORD_W:0]   xi, yi, xj, yj, dy;
      logic signed [PROD_W-1:0]  lhs, rhs;
      odd = 1'b0;
      n = zone_count[z];
      j = n - 1;
      for (i = 0; i < n; i++) begin
         xi = vert_x[z][i];
         yi = vert_y[z][i];
         xj = vert_x[z][j];
         yj = vert_y[z][j];
         if ((yi > py) != (yj > py)) begin
            dy = yj - yi;
            lhs = (px - xi) * dy;
            rhs = (xj - xi) * (py - yi);
            if (dy > 0 ? lhs < rhs : lhs > rhs)
               odd = ~odd;
         end
         j = i;
      end
      return odd;
   endfunction

   function automatic zone_answer_type apply_transaction();
      zone_answer_type ans;
      int              z;
      ans = '0;
      case (req_mode)
         MODE_VERTEX: begin
            vert_x[req_zone_index][req_vertex_index] = req_coord_x;
            vert_y[req_zone_index][req_vertex_index] = req_coord_y;
         end
         MODE_HEADER: begin
            zone_kind[req_zone_index] = req_type_code;
            zone_count[req_zone_index] = (req_vertex_count > MAX_VERTICES) ?
                                         CNT_W'(MAX_VERTICES) : req_vertex_count;
         end
         MODE_QUERY: begin
            ans.is_query = 1'b1;
            if (req_pose_valid) begin
               for (z = 0; z < MAX_ZONES && !ans.hit; z++) begin
                  if (zone_count[z] >= MIN_VERTICES && zone_kind[z] == req_type_code &&
                      point_in_zone(z, req_coord_x, req_coord_y)) begin
                     ans.hit = 1'b1;
                     ans.zone = z[3:0];
                  end
               end
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   task automatic compare_field(input string name, input logic [3:0] expv,
                                input logic [3:0] act);
      if (act !== expv) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, expv, act);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      zone_answer_type want;
      int              z;
      if (reset) begin
         for (z = 0; z < MAX_ZONES; z++) begin
            zone_kind[z] = '0;
            zone_count[z] = '0;
         end
         answer_queue.delete();
         fail_count = 0;
         inside_count = 0;
      end else begin
         // Results are handled first so that a result always meets the oldest
         // expectation, never the one pushed at this same edge.
         if (rsp_valid && !rsp_stall) begin
            if (answer_queue.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual is_query %0b inside %0b zone %0d",
                        $time, rsp_is_query, rsp_inside_res, rsp_matched_zone);
               fail_count++;
            end else begin
               want = answer_queue.pop_front();
               compare_field("is_query", 4'(want.is_query), 4'(rsp_is_query));
               compare_field("inside_res", 4'(want.hit), 4'(rsp_inside_res));
               compare_field("matched_zone", want.zone, rsp_matched_zone);
            end
         end
         if (req_valid && !req_stall) begin
            want = apply_transaction();
            if (want.hit)
               inside_count++;
            answer_queue.insert(answer_queue.size(), want);
         end
      end
      outstanding = answer_queue.size();
   end

endmodule

// File: tb/tb_typed_zone_point_in_polygon.sv
`timescale 1ns / 1ps

module tb_typed_zone_point_in_polygon;
   import tzpip_pkg::*;

   localparam logic [1:0] MODE_UNUSED  = 2'd3;
   localparam int         IDLE_PCT     = 15;
   localparam int         METRE        = 65536;
   localparam int         RANDOM_ITEMS = 1170;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_mode;
   logic [3:0]  req_zone_index;
   logic [4:0]  req_vertex_index;
   logic [31:0] req_coord_x;
   logic [31:0] req_coord_y;
   logic [3:0]  req_type_code;
   logic [5:0]  req_vertex_count;
   logic        req_pose_valid;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_is_query;
   logic        rsp_inside_res;
   logic [3:0]  rsp_matched_zone;

   int fail_count, outstanding, inside_count;
   int items_sent, queries_sent, zones_built;
   bit quiet;

   // What the stimulus knows about the zone table, so that no valid zone is ever
   // built on a vertex that was never written and queries can aim at real zones.
   logic [TYPE_W-1:0] shadow_type [MAX_ZONES];
   int                shadow_count [MAX_ZONES];
   bit                written [MAX_ZONES][MAX_VERTICES];
   int                box_x [MAX_ZONES];
   int                box_y [MAX_ZONES];
   int                box_r [MAX_ZONES];
   bit                box_grid [MAX_ZONES];

   typed_zone_point_in_polygon DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_zone_index   (req_zone_index),
      .req_vertex_index (req_vertex_index),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .req_type_code    (req_type_code),
      .req_vertex_count (req_vertex_count),
      .req_pose_valid   (req_pose_valid),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_is_query     (rsp_is_query),
      .rsp_inside_res   (rsp_inside_res),
      .rsp_matched_zone (rsp_matched_zone)
   );

   zone_query_checker u_zone_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_zone_index   (req_zone_index),
      .req_vertex_index (req_vertex_index),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .req_type_code    (req_type_code),
      .req_vertex_count (req_vertex_count),
      .req_pose_valid   (req_pose_valid),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_is_query     (rsp_is_query),
      .rsp_inside_res   (rsp_inside_res),
      .rsp_matched_zone (rsp_matched_zone),
      .fail_count       (fail_count),
      .outstanding      (outstanding),
      .inside_count     (inside_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #150_000_000;
      $display("typed_zone_point_in_polygon: mismatch");
      $finish;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= !quiet && ($urandom_range(99, 0) < IDLE_PCT);
      end
   end

   function automatic int near(input int c, input int r);
      return c + int'($urandom_range(32'(2 * r), 0)) - r;
   endfunction

   function automatic int valid_zone_count();
      int z, n;
      n = 0;
      for (z = 0; z < MAX_ZONES; z++)
         if (shadow_count[z] >= MIN_VERTICES)
            n++;
      return n;
   endfunction

   function automatic int pick_zone();
      int z;
      int list [$];
      for (z = 0; z < MAX_ZONES; z++)
         if (shadow_count[z] >= MIN_VERTICES)
            list.insert(list.size(), z);
      if (list.size() == 0)
         return -1;
      return list[$urandom_range(list.size() - 1, 0)];
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance with
   // valid still high, so the caller must follow at once with another transaction
   // or lower valid.
   task automatic send_txn(input logic [1:0] mode, input logic [3:0] zi, input logic [4:0] vi,
                           input logic [31:0] x, input logic [31:0] y, input logic [3:0] t,
                           input logic [5:0] cnt, input logic pose);
      while (!quiet && $urandom_range(99, 0) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_zone_index   <= zi;
      req_vertex_index <= vi;
      req_coord_x      <= x;
      req_coord_y      <= y;
      req_type_code    <= t;
      req_vertex_count <= cnt;
      req_pose_valid   <= pose;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic put_vertex(input int z, input int v, input logic [31:0] x,
                             input logic [31:0] y);
      send_txn(MODE_VERTEX, z[3:0], v[4:0], x, y, 4'($urandom), 6'($urandom), 1'($urandom));
      written[z][v] = 1'b1;
   endtask

   task automatic put_header(input int z, input logic [3:0] t, input logic [5:0] cnt);
      int n, v;
      n = (cnt > MAX_VERTICES) ? MAX_VERTICES : cnt;
      if (n >= MIN_VERTICES)
         for (v = 0; v < n; v++)
            if (!written[z][v])
               put_vertex(z, v, $urandom, $urandom);
      send_txn(MODE_HEADER, z[3:0], 5'($urandom), $urandom, $urandom, t, cnt, 1'($urandom));
      shadow_type[z] = t;
      shadow_count[z] = n;
   endtask

   task automatic put_query(input logic [31:0] x, input logic [31:0] y, input logic [3:0] t,
                            input logic pose);
      send_txn(MODE_QUERY, 4'($urandom), 5'($urandom), x, y, t, 6'($urandom), pose);
      queries_sent++;
   endtask

   // Grid polygons put vertices and query points on shared lines, so points on
   // edges and on vertices come up often; the others are scattered boxes of any size.
   task automatic build_zone(input int z, input logic [3:0] t);
      int         n, v, g, r, roll;
      logic [5:0] cnt;
      bit         grid;
      roll = $urandom_range(99, 0);
      if (roll < 80)
         n = $urandom_range(8, 3);
      else if (roll < 90)
         n = $urandom_range(31, 9);
      else
         n = MAX_VERTICES;
      cnt = (n == MAX_VERTICES) ? 6'($urandom_range(63, 32)) : 6'(n);
      grid = 1'($urandom_range(1, 0));
      g = METRE << $urandom_range(8, 0);
      r = 1 << $urandom_range(30, 4);
      if (grid) begin
         box_x[z] = (int'($urandom_range(20, 0)) - 10) * g;
         box_y[z] = (int'($urandom_range(20, 0)) - 10) * g;
         box_r[z] = g;
      end else begin
         box_x[z] = ($urandom_range(3, 0) == 0) ? int'($urandom) : near(0, r);
         box_y[z] = ($urandom_range(3, 0) == 0) ? int'($urandom) : near(0, r);
         box_r[z] = r;
      end
      box_grid[z] = grid;
      for (v = 0; v < n; v++) begin
         if (grid)
            put_vertex(z, v, box_x[z] + (int'($urandom_range(8, 0)) - 4) * g,
                       box_y[z] + (int'($urandom_range(8, 0)) - 4) * g);
         else
            put_vertex(z, v, near(box_x[z], r), near(box_y[z], r));
      end
      put_header(z, t, cnt);
      zones_built++;
   endtask

   task automatic random_query();
      int         z, r;
      logic [3:0] t;
      logic [31:0] x, y;
      z = pick_zone();
      t = (z >= 0 && $urandom_range(99, 0) < 80) ? shadow_type[z] : 4'($urandom);
      if (z >= 0 && $urandom_range(99, 0) < 70) begin
         r = box_r[z];
         if (box_grid[z]) begin
            x = box_x[z] + (int'($urandom_range(10, 0)) - 5) * r;
            y = box_y[z] + (int'($urandom_range(10, 0)) - 5) * r;
         end else begin
            x = near(box_x[z], r + r / 2);
            y = near(box_y[z], r + r / 2);
         end
      end else begin
         x = $urandom;
         y = $urandom;
      end
      put_query(x, y, t, $urandom_range(99, 0) < 90);
   endtask

   initial begin
      int z, start, roll;
      bit paused;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_mode         = MODE_VERTEX;
      req_zone_index   = '0;
      req_vertex_index = '0;
      req_coord_x      = '0;
      req_coord_y      = '0;
      req_type_code    = '0;
      req_vertex_count = '0;
      req_pose_valid   = 1'b0;
      quiet            = 1'b0;
      items_sent       = 0;
      queries_sent     = 0;
      zones_built      = 0;
      for (z = 0; z < MAX_ZONES; z++) begin
         shadow_type[z]  = '0;
         shadow_count[z] = 0;
         box_x[z]        = 0;
         box_y[z]        = 0;
         box_r[z]        = METRE;
         box_grid[z]     = 1'b1;
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: empty table, unused mode, a square around the origin, invalid headers,
      // points on an edge and a vertex, a pose that is missing, and a zone whose
      // corners sit at the extremes of the coordinate range.
      put_query(32'd0, 32'd0, 4'd0, 1'b1);
      send_txn(MODE_UNUSED, 4'($urandom), 5'($urandom), $urandom, $urandom, 4'($urandom),
               6'($urandom), 1'b1);
      put_vertex(0, 0, -METRE, -METRE);
      put_vertex(0, 1, METRE, -METRE);
      put_vertex(0, 2, METRE, METRE);
      put_vertex(0, 3, -METRE, METRE);
      put_header(0, 4'd5, 6'd4);
      put_header(1, 4'd5, 6'd2);
      put_header(3, 4'd5, 6'd0);
      put_query(32'd0, 32'd0, 4'd5, 1'b1);
      put_query(32'd0, 32'd0, 4'd6, 1'b1);
      put_query(32'd0, 32'd0, 4'd5, 1'b0);
      put_query(METRE, 32'd0, 4'd5, 1'b1);
      put_query(-METRE, -METRE, 4'd5, 1'b1);
      put_vertex(2, 0, 32'h8000_0000, 32'h8000_0000);
      put_vertex(2, 1, 32'h7FFF_FFFF, 32'h8000_0000);
      put_vertex(2, 2, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      put_vertex(2, 3, 32'h8000_0000, 32'h7FFF_FFFF);
      put_header(2, 4'd15, 6'd4);
      box_r[2] = 1 << 30;
      box_grid[2] = 1'b0;
      put_query(32'h8000_0000, 32'h8000_0000, 4'd15, 1'b1);
      put_query(32'd0, 32'd0, 4'd15, 1'b1);
      put_query(32'h7FFF_FFFF, 32'd0, 4'd15, 1'b1);

      // Random part: mostly queries against loaded zones, with zone builds,
      // invalidating headers, stray vertex writes and the unused mode mixed in.
      start = items_sent;
      paused = 1'b0;
      while (items_sent < start + RANDOM_ITEMS) begin
         quiet = (items_sent >= start + 300) && (items_sent < start + 500);
         if (!paused && items_sent >= start + 650) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            do
               @(negedge clock);
            while (outstanding != 0);
         end
         roll = $urandom_range(99, 0);
         if (valid_zone_count() < 4 || roll < 9)
            build_zone($urandom_range(15, 0), ($urandom_range(99, 0) < 75) ?
                       4'($urandom_range(3, 0)) : 4'($urandom));
         else if (roll < 13)
            put_header($urandom_range(15, 0), 4'($urandom), 6'($urandom_range(2, 0)));
         else if (roll < 16)
            send_txn(MODE_UNUSED, 4'($urandom), 5'($urandom), $urandom, $urandom,
                     4'($urandom), 6'($urandom), 1'($urandom));
         else if (roll < 20)
            put_vertex($urandom_range(15, 0), $urandom_range(31, 0), $urandom, $urandom);
         else
            random_query();
      end
      quiet = 1'b0;

      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (outstanding != 0);
      repeat (40) @(negedge clock);

      $display("Sent %0d transactions: %0d queries, %0d of them expected inside a zone.",
               items_sent, queries_sent, inside_count);
      $display("Loaded %0d polygon zones; runs had invalid zones, saturated counts and mode 3.",
               zones_built);
      if (fail_count == 0)
         $display("typed_zone_point_in_polygon: match");
      else
         $display("typed_zone_point_in_polygon: mismatch");
      $finish;
   end

endmodule
